// File: rtl/ptw_pkg.sv
package ptw_pkg;

  // sizing of the table store
  localparam int unsigned TABLE_COUNT = 64;
  localparam int unsigned LEVELS      = 4;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned SLOT_W      = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int unsigned USED_W      = $clog2(TABLE_COUNT + 1);
  localparam int unsigned LVL_W       = $clog2(LEVELS + 1);
  localparam int unsigned ADDR_W      = SLOT_W + IDX_W;
  localparam int unsigned DEPTH       = TABLE_COUNT * (1 << IDX_W);

  // field widths
  localparam int unsigned VPAGE_W = 36;
  localparam int unsigned FRAME_W = 40;
  localparam int unsigned FLAGS_W = 12;
  localparam int unsigned ENTRY_W = 64;

  localparam logic [ENTRY_W-1:0] ADDR_FIELD = {12'h0, {FRAME_W{1'b1}}, 12'h0};

  // command codes
  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_MAPPED      = 2'd1,
    ST_NOT_PRESENT = 2'd2,
    ST_NO_TABLES   = 2'd3
  } status_e;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  // store access from the walker
  typedef struct packed {
    logic               rd_en;
    addr_t              rd_addr;
    logic               wr_en;
    addr_t              wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } mem_req_t;

  // result handed to the output register
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [FRAME_W-1:0] old_frame;
  } result_t;

  // 9-bit table index of a virtual page at a given level
  function automatic logic [IDX_W-1:0] level_index(logic [VPAGE_W-1:0] vp, lvl_t lvl);
    logic [VPAGE_W-1:0] s;
    logic [5:0]         sh;
    sh = 6'(lvl - lvl_t'(1)) * 6'd9;
    s  = vp >> sh;
    return s[IDX_W-1:0];
  endfunction

endpackage

// File: rtl/ptw_store.sv
module ptw_store import ptw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mem_req_t           req_i,
  output logic [ENTRY_W-1:0] rd_data_o,
  output logic               ready_o
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  addr_t              clr_q, clr_d;
  logic               busy_q, busy_d;

  // clearing pass after reset, one entry per cycle
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + addr_t'(1);
      if (clr_q == addr_t'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;
  assign ready_o   = ~busy_q;

endmodule

// File: rtl/ptw_walk.sv
module ptw_walk import ptw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [VPAGE_W-1:0] virt_page_i,
  input  logic [FRAME_W-1:0] phys_frame_i,
  input  logic [FLAGS_W-1:0] entry_flags_i,
  input  logic [FRAME_W-1:0] base_frame_i,
  input  logic               store_ready_i,
  input  logic [ENTRY_W-1:0] rd_data_i,
  output mem_req_t           mem_o,
  input  logic               out_free_i,
  output result_t            res_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic                cmd_q;
  logic [VPAGE_W-1:0]  vp_q;
  logic [FRAME_W-1:0]  pf_q;
  logic [FLAGS_W-1:0]  fl_q;
  lvl_t                lvl_q, lvl_d;
  addr_t               pos_q, pos_d;
  logic [USED_W-1:0]   used_q, used_d;
  status_e             status_q, status_d;
  logic [FRAME_W-1:0]  old_q, old_d;

  logic [ENTRY_W-1:0]  e;
  logic [FRAME_W-1:0]  e_frame, child, fresh_frame;
  logic [SLOT_W-1:0]   next_slot;
  logic                accept;

  assign e           = rd_data_i;
  assign e_frame     = e[12 +: FRAME_W];
  assign child       = e_frame - base_frame_i;
  assign fresh_frame = base_frame_i + FRAME_W'(used_q);
  assign accept      = in_valid_i & in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);

  // walk sequencer
  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    pos_d     = pos_q;
    used_d    = used_q;
    status_d  = status_q;
    old_d     = old_q;
    next_slot = '0;
    mem_o     = '0;
    res_o     = '0;
    unique case (state_q)
      S_CLEAR: begin
        if (store_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = {SLOT_W'(0), level_index(virt_page_i, lvl_t'(LEVELS))};
          pos_d         = mem_o.rd_addr;
          lvl_d         = lvl_t'(LEVELS);
          status_d      = ST_DONE;
          old_d         = '0;
          state_d       = S_WALK;
        end
      end
      S_WALK: begin
        if (lvl_q == lvl_t'(1)) begin
          // leaf entry
          state_d = S_DONE;
          if (cmd_q == CMD_UNMAP) begin
            mem_o.wr_en   = 1'b1;
            mem_o.wr_addr = pos_q;
            mem_o.wr_data = '0;
          end else if (e[0]) begin
            status_d = ST_MAPPED;
            old_d    = e_frame;
          end else begin
            mem_o.wr_en   = 1'b1;
            mem_o.wr_addr = pos_q;
            mem_o.wr_data = ((e | ENTRY_W'(fl_q)) & ~ADDR_FIELD)
                          | (ENTRY_W'(pf_q) << 12);
          end
        end else if (e[0]) begin
          // follow an existing link
          if (child >= FRAME_W'(used_q)) begin
            status_d = ST_NOT_PRESENT;
            state_d  = S_DONE;
          end else begin
            next_slot     = child[SLOT_W-1:0];
            mem_o.rd_en   = 1'b1;
            mem_o.rd_addr = {next_slot, level_index(vp_q, lvl_q - lvl_t'(1))};
            pos_d         = mem_o.rd_addr;
            lvl_d         = lvl_q - lvl_t'(1);
          end
        end else if (cmd_q == CMD_UNMAP) begin
          status_d = ST_NOT_PRESENT;
          state_d  = S_DONE;
        end else if (used_q >= USED_W'(TABLE_COUNT)) begin
          status_d = ST_NO_TABLES;
          state_d  = S_DONE;
        end else begin
          // create a table from the bump counter and link it
          next_slot     = used_q[SLOT_W-1:0];
          used_d        = used_q + USED_W'(1);
          mem_o.wr_en   = 1'b1;
          mem_o.wr_addr = pos_q;
          mem_o.wr_data = (e & ~ADDR_FIELD) | (ENTRY_W'(fresh_frame) << 12)
                        | ENTRY_W'(1);
          mem_o.rd_en   = 1'b1;
          mem_o.rd_addr = {next_slot, level_index(vp_q, lvl_q - lvl_t'(1))};
          pos_d         = mem_o.rd_addr;
          lvl_d         = lvl_q - lvl_t'(1);
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_o.valid     = 1'b1;
          res_o.status    = status_q;
          res_o.old_frame = old_q;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      used_q  <= USED_W'(1);
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  // request and walk payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      vp_q  <= virt_page_i;
      pf_q  <= phys_frame_i;
      fl_q  <= entry_flags_i;
    end
    lvl_q    <= lvl_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    old_q    <= old_d;
  end

endmodule

// File: rtl/page_table_map_unmap_walker_core.sv
// Page table map/unmap walker.
// Input channel (in_valid_i / in_ready_o) carries one request: map or unmap
// of one 4 KiB virtual page, with frame and flags for a map. Output channel
// (out_valid_o / out_ready_i) returns one status and old frame per request.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes the frame number
// of the root table slot; it is always ready, and the user must write it
// only while idle, which the block does not enforce. All tables live in one
// single-port-write, registered-read memory; at each level the entry read
// issued in the previous cycle is checked, a missing table is linked and
// the next level's read is issued. A walk can stop before the leaf level
// with status not present or no tables.
// One request is in the walker at a time; the next is accepted once the
// result has moved into the output register.
// When the receiver stalls, the result waits in the output register and the
// walker takes one more request, then holds its result until that slot frees.
// After reset the memory is cleared one entry per cycle, TABLE_COUNT * 512
// entries (32768 by default); in_ready_o stays low until that pass ends.
module page_table_map_unmap_walker_core import ptw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [FRAME_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [VPAGE_W-1:0] virt_page_i,
  input  logic [FRAME_W-1:0] phys_frame_i,
  input  logic [FLAGS_W-1:0] entry_flags_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [FRAME_W-1:0] old_frame_o
);

  logic [FRAME_W-1:0] base_q;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rd_data;
  logic               store_ready;
  result_t            res;
  logic               out_valid_q;
  status_e            status_q;
  logic [FRAME_W-1:0] old_q;
  logic               out_free;

  // root frame register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  ptw_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data),
    .ready_o   (store_ready)
  );

  ptw_walk u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .virt_page_i   (virt_page_i),
    .phys_frame_i  (phys_frame_i),
    .entry_flags_i (entry_flags_i),
    .base_frame_i  (base_q),
    .store_ready_i (store_ready),
    .rd_data_i     (rd_data),
    .mem_o         (mem_req),
    .out_free_i    (out_free),
    .res_o         (res)
  );

  // output register
  assign out_free = ~out_valid_q | out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      old_q    <= res.old_frame;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign old_frame_o = old_q;

endmodule

// File: rtl/ptw_checker.sv
module ptw_checker import ptw_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic [FRAME_W-1:0] old_frame_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(old_frame_o))
    else $error("result changed while stalled");

  // old frame only reported with already mapped
  a_old_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_MAPPED) |-> old_frame_o == '0)
    else $error("old frame set without already mapped status");

  // one request in the walker at a time
  a_one_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted during a walk");

  // a new result only comes from a busy walker
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a walk");

endmodule

bind page_table_map_unmap_walker_core ptw_checker u_ptw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .old_frame_o (old_frame_o)
);

// File: tb/page_table_map_unmap_walker_core_test.sv
`timescale 1ns / 1ps

module page_table_map_unmap_walker_core_test;
  import ptw_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned POOL_SIZE     = 16;
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef struct {
    status_e            status;
    logic [FRAME_W-1:0] old_frame;
  } walk_result_t;

  // block inputs, all known from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic [FRAME_W-1:0] cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic               cmd_i         = CMD_MAP;
  logic [VPAGE_W-1:0] virt_page_i   = '0;
  logic [FRAME_W-1:0] phys_frame_i  = '0;
  logic [FLAGS_W-1:0] entry_flags_i = '0;
  logic               out_ready_i   = 1'b0;

  logic               cfg_ready_o;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [1:0]         status_o;
  logic [FRAME_W-1:0] old_frame_o;

  // shadow copy of the page tables and walker state
  logic [ENTRY_W-1:0] shadow_tables [DEPTH];
  int unsigned        tables_created = 1;
  logic [FRAME_W-1:0] root_base_frame = '0;

  walk_result_t       walk_results_due [$];
  logic [VPAGE_W-1:0] vpage_pool [POOL_SIZE];

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;

  page_table_map_unmap_walker_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .virt_page_i   (virt_page_i),
    .phys_frame_i  (phys_frame_i),
    .entry_flags_i (entry_flags_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .old_frame_o   (old_frame_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("page_table_map_unmap_walker_core_test: errors");
      $finish;
    end
  end

  // result receiver with random stalls and requested long hold-offs
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // result checker against the oldest predicted walk
  always @(posedge clk_i) begin : check_results
    walk_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (walk_results_due.size() == 0) begin
        report_mismatch("result with no request", 64'(status_o), 64'(0));
      end else begin
        want = walk_results_due.pop_front();
        if (status_o !== 2'(want.status))
          report_mismatch("status", 64'(status_o), 64'(want.status));
        if (old_frame_o !== want.old_frame)
          report_mismatch("old_frame", 64'(old_frame_o), 64'(want.old_frame));
      end
    end
  end

  function automatic int unsigned entry_index(input logic [VPAGE_W-1:0] vp, input int lvl);
    logic [63:0] w;
    w = 64'(vp) >> (IDX_W * (lvl - 1));
    return int'(w[IDX_W-1:0]);
  endfunction

  // walk the shadow tables for one request and apply its writes
  task automatic walk_page_table(input logic cmd, input logic [VPAGE_W-1:0] vp,
                                 input logic [FRAME_W-1:0] pf,
                                 input logic [FLAGS_W-1:0] fl,
                                 output walk_result_t res);
    int unsigned        slot;
    int unsigned        pos;
    int                 lvl;
    bit                 reached_leaf;
    logic [ENTRY_W-1:0] e;
    logic [FRAME_W-1:0] child;
    logic [FRAME_W-1:0] link;
    slot          = 0;
    reached_leaf  = 1'b1;
    res.status    = ST_DONE;
    res.old_frame = '0;
    for (lvl = LEVELS; lvl >= 2 && reached_leaf; lvl--) begin
      pos = (slot << IDX_W) + entry_index(vp, lvl);
      e   = shadow_tables[pos];
      if (e[0]) begin
        child = e[12 +: FRAME_W] - root_base_frame;
        if (child >= tables_created || child >= TABLE_COUNT) begin
          res.status   = ST_NOT_PRESENT;
          reached_leaf = 1'b0;
        end else begin
          slot = int'(child);
        end
      end else if (cmd == CMD_UNMAP) begin
        res.status   = ST_NOT_PRESENT;
        reached_leaf = 1'b0;
      end else if (tables_created >= TABLE_COUNT) begin
        res.status   = ST_NO_TABLES;
        reached_leaf = 1'b0;
      end else begin
        // link a fresh table from the bump counter
        link               = root_base_frame + FRAME_W'(tables_created);
        e[12 +: FRAME_W]   = link;
        e[0]               = 1'b1;
        shadow_tables[pos] = e;
        slot               = tables_created;
        tables_created++;
      end
    end
    if (reached_leaf) begin
      pos = (slot << IDX_W) + entry_index(vp, 1);
      e   = shadow_tables[pos];
      if (cmd == CMD_UNMAP) begin
        shadow_tables[pos] = '0;
      end else if (e[0]) begin
        res.status    = ST_MAPPED;
        res.old_frame = e[12 +: FRAME_W];
      end else begin
        e[FLAGS_W-1:0]     = e[FLAGS_W-1:0] | fl;
        e[12 +: FRAME_W]   = pf;
        shadow_tables[pos] = e;
      end
    end
  endtask

  // offer one request, called and returning at a falling edge
  task automatic send_request(input logic cmd, input logic [VPAGE_W-1:0] vp,
                              input logic [FRAME_W-1:0] pf,
                              input logic [FLAGS_W-1:0] fl);
    walk_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    virt_page_i   <= vp;
    phys_frame_i  <= pf;
    entry_flags_i <= fl;
    do @(posedge clk_i); while (!in_ready_o);
    walk_page_table(cmd, vp, pf, fl, res);
    walk_results_due.push_back(res);
    @(negedge clk_i);
  endtask

  // stop offering and let every outstanding result drain
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (walk_results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_table_base(input logic [FRAME_W-1:0] value);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    root_base_frame = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_request();
    logic [VPAGE_W-1:0] vp;
    logic [FRAME_W-1:0] pf;
    logic [FLAGS_W-1:0] fl;
    logic               cmd;
    int unsigned        pick;
    int unsigned        pool_pick;
    pick      = $urandom_range(0, 99);
    pool_pick = $urandom_range(0, POOL_SIZE - 1);
    if (pick < 15) begin
      // fresh region, costs up to three tables
      vp = VPAGE_W'({$urandom, $urandom});
      vpage_pool[pool_pick] = vp;
    end else begin
      // known region, mostly a handful of leaves
      vp = vpage_pool[pool_pick];
      if (pick < 25) vp[2*IDX_W-1:IDX_W] = IDX_W'($urandom);
      if ($urandom_range(0, 3) != 0) vp[IDX_W-1:0] = IDX_W'($urandom_range(0, 15));
      else vp[IDX_W-1:0] = IDX_W'($urandom);
    end
    cmd = ($urandom_range(0, 9) < 6) ? CMD_MAP : CMD_UNMAP;
    case ($urandom_range(0, 9))
      0: pf = '0;
      1: pf = '1;
      default: pf = FRAME_W'({$urandom, $urandom});
    endcase
    fl = FLAGS_W'($urandom);
    if ($urandom_range(0, 3) != 0) fl[0] = 1'b1;
    send_request(cmd, vp, pf, fl);
  endtask

  // extremes of the fields and the done, mapped and not present outcomes
  task automatic test_directed_walks();
    send_idle_pct = 31;
    recv_idle_pct = 80;
    write_table_base('1);
    send_request(CMD_MAP,   '0, '0, 12'h001);
    send_request(CMD_MAP,   '0, 40'h1, 12'hFFF);
    send_request(CMD_MAP,   '1, '1, 12'hFFF);
    send_request(CMD_MAP,   '1, '0, 12'h001);
    send_request(CMD_UNMAP, '1, '1, 12'hFFF);
    // unmap of a leaf that is already clear
    send_request(CMD_UNMAP, '1, '0, 12'h000);
    // leaf left not present with stale flags, then overwritten
    send_request(CMD_MAP,   '1, 40'hA5_A5A5_A5A5, 12'hFFE);
    send_request(CMD_MAP,   '1, 40'h5A_5A5A_5A5A, 12'h000);
    send_request(CMD_MAP,   '1, 40'h01_2345_6789, 12'h001);
    send_request(CMD_MAP,   '1, 40'h0, 12'h001);
    // missing levels on unmap
    send_request(CMD_UNMAP, 36'h8_0000_0000, '1, 12'hFFF);
    send_request(CMD_UNMAP, 36'h0_0000_0200, '0, 12'h000);
    send_request(CMD_UNMAP, 36'h0_0004_0000, '0, 12'h000);
    send_request(CMD_MAP,   36'h0_0000_0200, 40'h7, 12'h003);
    send_request(CMD_UNMAP, '0, '1, 12'h001);
    send_request(CMD_MAP,   '0, 40'hFF_0000_0001, 12'h801);
  endtask

  // links followed under a changed table base
  task automatic test_relinked_base();
    write_table_base('0);
    send_request(CMD_MAP,   '0, 40'h33, 12'h001);
    send_request(CMD_UNMAP, '1, '0, 12'h000);
    send_request(CMD_MAP,   36'h0_0000_0200, 40'h44, 12'h001);
    write_table_base(FRAME_W'({$urandom, $urandom}));
    send_request(CMD_MAP,   '0, 40'h55, 12'h001);
    send_request(CMD_UNMAP, '0, '0, 12'h000);
    send_request(CMD_MAP,   '1, 40'h66, 12'h001);
    send_request(CMD_MAP,   36'h4_0000_0000, 40'h77, 12'h005);
    send_request(CMD_UNMAP, 36'h4_0000_0000, '0, 12'h000);
    write_table_base('1);
  endtask

  task automatic test_random_walks(input int unsigned count, input int unsigned send_pct,
                                   input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_random_request();
    wait_for_results();
  endtask

  // receiver holds off while requests keep coming
  task automatic test_input_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_req = HOLD_CYCLES;
    @(negedge clk_i);
    repeat (12) send_random_request();
    wait_for_results();
  endtask

  initial begin
    for (int unsigned k = 0; k < DEPTH; k++) shadow_tables[k] = '0;
    for (int unsigned k = 0; k < POOL_SIZE; k++) vpage_pool[k] = (k % 2 == 0) ? '0 : '1;

    // reset, then wait out the table clearing pass
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);

    test_directed_walks();
    test_relinked_base();
    test_random_walks(125, 31, 80);
    test_random_walks(125, 80, 31);
    test_random_walks(125, 0, 0);
    test_input_backpressure();

    if (error_count == 0 && walk_results_due.size() == 0) begin
      $display("page_table_map_unmap_walker_core_test: clean");
    end else begin
      $display("page_table_map_unmap_walker_core_test: errors");
    end
    $finish;
  end

endmodule
